/* src/tccw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer package
// Shared constants, request codes, microcode types and the control store.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;
  localparam int unsigned CELL_W      = 16;
  localparam int unsigned ATTR_W      = 8;
  localparam int unsigned CHAR_W      = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_MOVE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;

  localparam int unsigned STEP_W = 4;

  localparam logic [STEP_W-1:0] S_DECODE    = 4'd0;
  localparam logic [STEP_W-1:0] S_PUTCH     = 4'd1;
  localparam logic [STEP_W-1:0] S_NEWLINE   = 4'd2;
  localparam logic [STEP_W-1:0] S_SCR_RD    = 4'd3;
  localparam logic [STEP_W-1:0] S_SCR_WR    = 4'd4;
  localparam logic [STEP_W-1:0] S_BLANK     = 4'd5;
  localparam logic [STEP_W-1:0] S_DONE      = 4'd6;
  localparam logic [STEP_W-1:0] S_CR        = 4'd7;
  localparam logic [STEP_W-1:0] S_MOVE      = 4'd8;
  localparam logic [STEP_W-1:0] S_CLEAR     = 4'd9;
  localparam logic [STEP_W-1:0] S_READ      = 4'd10;
  localparam logic [STEP_W-1:0] S_READ_WAIT = 4'd11;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_RD_SRC,
    MEM_RD_CELL,
    MEM_WR_CHAR,
    MEM_WR_COPY,
    MEM_WR_BLANK
  } mem_op_e;

  typedef enum logic [1:0] {
    PTR_KEEP,
    PTR_CLR,
    PTR_INC
  } ptr_op_e;

  typedef enum logic [2:0] {
    CUR_NONE,
    CUR_HOME,
    CUR_CR,
    CUR_NL,
    CUR_STEP,
    CUR_MOVE
  } cur_op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_DISPATCH,
    C_COL_NOT_LAST,
    C_ROW_NOT_LAST,
    C_PTR_NOT_COPY_END,
    C_PTR_NOT_ALL_END
  } cond_e;

  typedef struct packed {
    mem_op_e             mem_op;
    ptr_op_e             ptr_op;
    cur_op_e             cur_op;
    logic                cell_ld;
    logic                done;
    cond_e               cond;
    logic [STEP_W-1:0]   target;
  } ctrl_t;

  function automatic ctrl_t uc_word(input mem_op_e m, input ptr_op_e p, input cur_op_e c,
                                    input logic ld, input logic dn, input cond_e cd,
                                    input logic [STEP_W-1:0] tg);
    ctrl_t w;
    w.mem_op  = m;
    w.ptr_op  = p;
    w.cur_op  = c;
    w.cell_ld = ld;
    w.done    = dn;
    w.cond    = cd;
    w.target  = tg;
    return w;
  endfunction

  // A conditional step jumps to its target when the condition holds and
  // falls through to the following step otherwise.
  function automatic ctrl_t uc_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    case (step)
      S_DECODE:    w = uc_word(MEM_NONE, PTR_KEEP, CUR_NONE, 1'b0, 1'b0, C_DISPATCH, S_DONE);
      S_PUTCH:     w = uc_word(MEM_WR_CHAR, PTR_KEEP, CUR_STEP, 1'b0, 1'b0,
                               C_COL_NOT_LAST, S_DONE);
      S_NEWLINE:   w = uc_word(MEM_NONE, PTR_CLR, CUR_NL, 1'b0, 1'b0,
                               C_ROW_NOT_LAST, S_DONE);
      S_SCR_RD:    w = uc_word(MEM_RD_SRC, PTR_KEEP, CUR_NONE, 1'b0, 1'b0, C_NEXT, S_DONE);
      S_SCR_WR:    w = uc_word(MEM_WR_COPY, PTR_INC, CUR_NONE, 1'b0, 1'b0,
                               C_PTR_NOT_COPY_END, S_SCR_RD);
      S_BLANK:     w = uc_word(MEM_WR_BLANK, PTR_INC, CUR_NONE, 1'b0, 1'b0,
                               C_PTR_NOT_ALL_END, S_BLANK);
      S_DONE:      w = uc_word(MEM_NONE, PTR_KEEP, CUR_NONE, 1'b0, 1'b1, C_JUMP, S_DECODE);
      S_CR:        w = uc_word(MEM_NONE, PTR_KEEP, CUR_CR, 1'b0, 1'b0, C_JUMP, S_DONE);
      S_MOVE:      w = uc_word(MEM_NONE, PTR_KEEP, CUR_MOVE, 1'b0, 1'b0, C_JUMP, S_DONE);
      S_CLEAR:     w = uc_word(MEM_NONE, PTR_CLR, CUR_HOME, 1'b0, 1'b0, C_JUMP, S_BLANK);
      S_READ:      w = uc_word(MEM_RD_CELL, PTR_KEEP, CUR_NONE, 1'b0, 1'b0, C_NEXT, S_DONE);
      S_READ_WAIT: w = uc_word(MEM_NONE, PTR_KEEP, CUR_NONE, 1'b1, 1'b0, C_JUMP, S_DONE);
      default:     w = uc_word(MEM_NONE, PTR_KEEP, CUR_NONE, 1'b0, 1'b0, C_JUMP, S_DONE);
    endcase
    return w;
  endfunction

endpackage

/* src/tccw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/text_console_char_writer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer
// Microcoded text screen engine with cursor, scroll, clear and cell read.
// ----------------------------------------------------------------------------
// Every request passes the decode step and ends in the done step; a tab does nothing else.
// Put writes the cell and steps the cursor; at the last column it wraps into a newline.
// A newline on the last row scrolls: each row is copied up and the last row blanked,
// one screen memory port access per cycle; clear homes the cursor and blanks every cell.
// A new request is taken in the cycle done_o is high; the receiver cannot stall.
// Reset homes the cursor and sets the attribute to 7; the screen is undefined until cleared.
module text_console_char_writer_unit #(
  parameter int unsigned COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  char_code_i,
  input  logic [4:0]  target_row_i,
  input  logic [6:0]  target_col_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output logic        done_o,
  output logic [4:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o,
  output logic [10:0] cursor_linear_o,
  output logic [15:0] cell_value_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned SW    = tccw_pkg::STEP_W;
  localparam int unsigned DW    = tccw_pkg::CELL_W;

  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [AW-1:0] COPY_END = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] ALL_END  = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_SPAN = AW'(COLUMNS);

  logic                  busy_q, busy_d;
  logic [SW-1:0]         upc_q, upc_d;
  logic [RW-1:0]         row_q, row_d;
  logic [CW-1:0]         col_q, col_d;
  logic [7:0]            attr_q;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [1:0]            req_q;
  logic [7:0]            char_q;
  logic [4:0]            trow_q;
  logic [6:0]            tcol_q;
  logic [DW-1:0]         cell_q;
  logic                  done_q;
  logic [4:0]            out_row_q;
  logic [6:0]            out_col_q;
  logic [10:0]           out_lin_q;
  logic [DW-1:0]         out_cell_q;

  tccw_pkg::ctrl_t       cw;
  logic [SW-1:0]         disp_step;
  logic [SW-1:0]         upc_inc;
  logic [RW-1:0]         row_sat;
  logic [CW-1:0]         col_sat;
  logic [AW-1:0]         cur_off;
  logic [AW-1:0]         rd_off;
  logic                  accept;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DW-1:0]         ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DW-1:0]         ram_rdata;

  assign accept      = start && !busy_q;
  assign busy        = busy_q;
  assign cfg_ready_o = 1'b1;
  assign cw          = tccw_pkg::uc_rom(upc_q);
  assign upc_inc     = upc_q + SW'(1);

  assign row_sat = (32'(trow_q) > ROWS - 1) ? ROW_LAST : RW'(trow_q);
  assign col_sat = (32'(tcol_q) > COLUMNS - 1) ? COL_LAST : CW'(tcol_q);
  assign cur_off = AW'(row_q * COLUMNS + col_q);
  assign rd_off  = AW'(row_sat * COLUMNS + col_sat);

  always_comb begin
    case (req_q)
      tccw_pkg::REQ_PUT: begin
        if (char_q == tccw_pkg::CH_NEWLINE) begin
          disp_step = tccw_pkg::S_NEWLINE;
        end else if (char_q == tccw_pkg::CH_RETURN) begin
          disp_step = tccw_pkg::S_CR;
        end else if (char_q == tccw_pkg::CH_TAB) begin
          disp_step = tccw_pkg::S_DONE;
        end else begin
          disp_step = tccw_pkg::S_PUTCH;
        end
      end
      tccw_pkg::REQ_MOVE:  disp_step = tccw_pkg::S_MOVE;
      tccw_pkg::REQ_CLEAR: disp_step = tccw_pkg::S_CLEAR;
      tccw_pkg::REQ_READ:  disp_step = tccw_pkg::S_READ;
      default:             disp_step = tccw_pkg::S_DONE;
    endcase
  end

  always_comb begin
    case (cw.cond)
      tccw_pkg::C_NEXT:             upc_d = upc_inc;
      tccw_pkg::C_JUMP:             upc_d = cw.target;
      tccw_pkg::C_DISPATCH:         upc_d = disp_step;
      tccw_pkg::C_COL_NOT_LAST:     upc_d = (col_q != COL_LAST) ? cw.target : upc_inc;
      tccw_pkg::C_ROW_NOT_LAST:     upc_d = (row_q != ROW_LAST) ? cw.target : upc_inc;
      tccw_pkg::C_PTR_NOT_COPY_END: upc_d = (ptr_q != COPY_END) ? cw.target : upc_inc;
      tccw_pkg::C_PTR_NOT_ALL_END:  upc_d = (ptr_q != ALL_END) ? cw.target : upc_inc;
      default:                      upc_d = cw.target;
    endcase
    if (accept) begin
      upc_d = tccw_pkg::S_DECODE;
    end else if (!busy_q) begin
      upc_d = upc_q;
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (busy_q && cw.done) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (busy_q) begin
      case (cw.cur_op)
        tccw_pkg::CUR_HOME: begin
          row_d = '0;
          col_d = '0;
        end
        tccw_pkg::CUR_CR: col_d = '0;
        tccw_pkg::CUR_NL: begin
          col_d = '0;
          if (row_q != ROW_LAST) begin
            row_d = row_q + RW'(1);
          end
        end
        tccw_pkg::CUR_STEP: col_d = (col_q == COL_LAST) ? '0 : col_q + CW'(1);
        tccw_pkg::CUR_MOVE: begin
          row_d = row_sat;
          col_d = col_sat;
        end
        default: begin
          row_d = row_q;
          col_d = col_q;
        end
      endcase
    end
  end

  always_comb begin
    case (cw.ptr_op)
      tccw_pkg::PTR_CLR: ptr_d = '0;
      tccw_pkg::PTR_INC: ptr_d = ptr_q + AW'(1);
      default:           ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = {attr_q, tccw_pkg::CH_SPACE};
    ram_re    = 1'b0;
    ram_raddr = ptr_q + ROW_SPAN;
    if (busy_q) begin
      case (cw.mem_op)
        tccw_pkg::MEM_RD_SRC: ram_re = 1'b1;
        tccw_pkg::MEM_RD_CELL: begin
          ram_re    = 1'b1;
          ram_raddr = rd_off;
        end
        tccw_pkg::MEM_WR_CHAR: begin
          ram_we    = 1'b1;
          ram_waddr = cur_off;
          ram_wdata = {attr_q, char_q};
        end
        tccw_pkg::MEM_WR_COPY: begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
        end
        tccw_pkg::MEM_WR_BLANK: ram_we = 1'b1;
        default: ram_we = 1'b0;
      endcase
    end
  end

  tccw_ram #(
    .WIDTH(DW),
    .DEPTH(CELLS)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= tccw_pkg::S_DECODE;
      row_q  <= '0;
      col_q  <= '0;
      attr_q <= tccw_pkg::ATTR_RESET;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      upc_q  <= upc_d;
      row_q  <= row_d;
      col_q  <= col_d;
      done_q <= busy_q && cw.done;
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      ptr_q <= ptr_d;
    end
    if (accept) begin
      req_q  <= req_type_i;
      char_q <= char_code_i;
      trow_q <= target_row_i;
      tcol_q <= target_col_i;
      cell_q <= '0;
    end else if (busy_q && cw.cell_ld) begin
      cell_q <= ram_rdata;
    end
    if (busy_q && cw.done) begin
      out_row_q  <= 5'(row_q);
      out_col_q  <= 7'(col_q);
      out_lin_q  <= 11'(row_q * COLUMNS + col_q);
      out_cell_q <= cell_q;
    end
  end

  assign done_o          = done_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_col_o    = out_col_q;
  assign cursor_linear_o = out_lin_q;
  assign cell_value_o    = out_cell_q;

`ifndef SYNTH
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("Result strobe while a transaction is still running.");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("Accepted transaction did not start the sequencer.");

  a_cursor_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= ROW_LAST) && (col_q <= COL_LAST))
    else $error("Cursor left the screen.");

  a_write_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (32'(ram_waddr) < CELLS))
    else $error("Screen write outside the memory.");
`endif

endmodule
